>>> rtl/php_pkg.sv
// shared constants and types for the pid heater power block
package php_pkg;

    // dividend width of the serial divider, covers gain * 50 * change
    localparam int DIV_W = 22;
    localparam int DIV_LEN_W = $clog2(DIV_W + 1);
    localparam int DIVISOR_W = 8;

    localparam int INTEGRAL_LIMIT_DEF = 300;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_DIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_DIV     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> rtl/php_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module php_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [php_pkg::DIV_W-1:0]      i_dividend,
    input  logic [php_pkg::DIVISOR_W-1:0]  i_divisor,
    input  logic [php_pkg::DIV_LEN_W-1:0]  i_len,
    output php_pkg::t_div_status           o_status,
    output logic [php_pkg::DIV_W-1:0]      o_quotient
);

    localparam int DivW = php_pkg::DIV_W;
    localparam int LenW = php_pkg::DIV_LEN_W;
    localparam int DsrW = php_pkg::DIVISOR_W;

    logic            r_busy;
    logic            r_done;
    logic [LenW-1:0] r_cnt;
    logic [DsrW-1:0] r_rem;
    logic [DsrW-1:0] r_dsr;
    logic [DivW-1:0] r_quo;

    logic [LenW-1:0] shift_amt;
    logic [DsrW:0]   rem_shift;
    logic            q_bit;
    logic [DsrW:0]   rem_diff;

    // left-align the dividend so only its low len bits are worked through
    assign shift_amt = LenW'(DivW) - i_len;
    assign rem_shift = {r_rem, r_quo[DivW-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dsr};
    assign q_bit     = (rem_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LenW'(1);
                if (r_cnt == LenW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend << shift_amt;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DivW-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[DsrW-1:0] : rem_shift[DsrW-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");

endmodule

>>> rtl/pid_heater_power_top.sv
// pid heater power top level: sequencer, state, registers and output stage
// m_axis_tvalid rises after the divisions, once the output register is free
// five serial divisions of 13, 15, 15, 15 and 22 bits, run one after another
// no new input is taken until the last result is loaded; all use one shared divider
// the next input is taken while a finished result waits in the output register
// synchronous active-low reset restores register defaults, clears integral and previous sample
module pid_heater_power_top #(
    parameter int INTEGRAL_LIMIT = php_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // measured_temperature
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // drive_percent[6:0], proportional_term[22:7], integral_term[37:23],
    // derivative_term[60:38], zero fill
    output logic [63:0]                     m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [php_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                      i_cfg_data
);

    localparam int DivW = php_pkg::DIV_W;
    localparam int LenW = php_pkg::DIV_LEN_W;
    localparam int IntW = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int SumW = 16;
    localparam int TotW = 25;

    localparam logic [LenW-1:0] LEN_STEP  = LenW'(13);
    localparam logic [LenW-1:0] LEN_PROP  = LenW'(15);
    localparam logic [LenW-1:0] LEN_INT   = LenW'(15);
    localparam logic [LenW-1:0] LEN_DERIV = LenW'(22);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_STEP,
        OP_PROP,
        OP_INT1,
        OP_INT2,
        OP_DERIV
    } t_op;

    // configuration
    logic [7:0] r_target;
    logic [7:0] r_kp;
    logic [7:0] r_ki;
    logic [7:0] r_kstep;
    logic [7:0] r_kd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 8'd0;
            r_kp     <= 8'd1;
            r_ki     <= 8'd1;
            r_kstep  <= 8'd1;
            r_kd     <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                php_pkg::REG_TARGET:     r_target <= i_cfg_data;
                php_pkg::REG_PROP_DIV:   r_kp     <= i_cfg_data;
                php_pkg::REG_INT_DIV:    r_ki     <= i_cfg_data;
                php_pkg::REG_INT_STEP:   r_kstep  <= i_cfg_data;
                php_pkg::REG_DERIV_GAIN: r_kd     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state;
    t_op    r_op;

    logic [7:0]             r_prev_temp;
    logic signed [9:0]      r_error;
    logic signed [8:0]      r_change;
    logic signed [IntW-1:0] r_integ;
    logic signed [15:0]     r_p;
    logic signed [15:0]     r_i1;
    logic signed [15:0]     r_i;
    logic signed [22:0]     r_d;
    logic                   r_out_valid;
    logic [63:0]            r_out_data;

    php_pkg::t_div_status   div_stat;
    logic [DivW-1:0]        div_quo;
    logic [DivW-1:0]        div_dividend;
    logic [7:0]             div_divisor;
    logic [LenW-1:0]        div_len;
    logic                   div_neg;
    logic                   div_start;

    // magnitudes of the signed operands
    logic [8:0]             err_mag;
    logic [7:0]             chg_mag;
    logic [IntW-1:0]        int_mag;
    logic [15:0]            i1_mag;
    logic [DivW-1:0]        err_w;
    logic [DivW-1:0]        int_w;
    logic [13:0]            chg50;
    logic [7:0]             kp_eff;
    logic [7:0]             ki_eff;
    logic [7:0]             ks_eff;

    assign err_mag = r_error[9] ? 9'(-r_error) : r_error[8:0];
    assign chg_mag = r_change[8] ? 8'(-r_change) : r_change[7:0];
    assign int_mag = r_integ[IntW-1] ? IntW'(-r_integ) : r_integ;
    assign i1_mag  = r_i1[15] ? 16'(-r_i1) : r_i1;
    assign err_w   = DivW'(err_mag);
    assign int_w   = DivW'(int_mag);
    assign chg50   = (14'(chg_mag) << 5) + (14'(chg_mag) << 4) + (14'(chg_mag) << 1);

    // a zero divisor behaves as one
    assign kp_eff = (r_kp == 8'd0) ? 8'd1 : r_kp;
    assign ki_eff = (r_ki == 8'd0) ? 8'd1 : r_ki;
    assign ks_eff = (r_kstep == 8'd0) ? 8'd1 : r_kstep;

    always_comb begin
        case (r_op)
            OP_STEP: begin
                div_dividend = (err_w << 3) + (err_w << 1);
                div_divisor  = ks_eff;
                div_len      = LEN_STEP;
                div_neg      = r_error[9];
            end
            OP_PROP: begin
                div_dividend = (err_w << 5) + (err_w << 4) + (err_w << 1);
                div_divisor  = kp_eff;
                div_len      = LEN_PROP;
                div_neg      = r_error[9];
            end
            OP_INT1: begin
                div_dividend = (int_w << 5) + (int_w << 4) + (int_w << 1);
                div_divisor  = ki_eff;
                div_len      = LEN_INT;
                div_neg      = r_integ[IntW-1];
            end
            OP_INT2: begin
                div_dividend = DivW'(i1_mag);
                div_divisor  = kp_eff;
                div_len      = LEN_INT;
                div_neg      = r_i1[15];
            end
            OP_DERIV: begin
                div_dividend = DivW'(chg50) * DivW'(r_kd);
                div_divisor  = kp_eff;
                div_len      = LEN_DERIV;
                div_neg      = r_change[8];
            end
            default: begin
                div_dividend = '0;
                div_divisor  = 8'd1;
                div_len      = LEN_STEP;
                div_neg      = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == S_LOAD);

    php_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_len      (div_len),
        .o_status   (div_stat),
        .o_quotient (div_quo)
    );

    // signed quotient, truncated toward zero
    logic signed [22:0]     quo_s;
    logic signed [SumW-1:0] int_sum;
    logic signed [SumW-1:0] int_lim;
    logic signed [IntW-1:0] int_next;

    assign quo_s   = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign int_lim = SumW'(INTEGRAL_LIMIT);
    assign int_sum = SumW'(r_integ) + SumW'($signed(quo_s[13:0]));

    always_comb begin
        if (int_sum > int_lim) begin
            int_next = IntW'(int_lim);
        end else if (int_sum < -int_lim) begin
            int_next = IntW'(-int_lim);
        end else begin
            int_next = IntW'(int_sum);
        end
    end

    // output assembly
    logic signed [TotW-1:0] total;
    logic [6:0]             drive;
    logic [14:0]            i_field;

    assign total = TotW'(r_p) + TotW'(r_i) - TotW'(r_d);

    always_comb begin
        if (total < 0) begin
            drive = 7'd0;
        end else if (total > TotW'(99)) begin
            drive = 7'd99;
        end else begin
            drive = total[6:0];
        end
        if (r_i > 16'sd16383) begin
            i_field = 15'h3fff;
        end else if (r_i < -16'sd16384) begin
            i_field = 15'h4000;
        end else begin
            i_field = r_i[14:0];
        end
    end

    logic in_xfer;
    logic out_load;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_STEP;
            r_prev_temp <= 8'd0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_error     <= $signed({1'b0, r_target, 1'b0})
                                       - $signed({2'b00, s_axis_tdata});
                        r_change    <= $signed({1'b0, s_axis_tdata})
                                       - $signed({1'b0, r_prev_temp});
                        r_prev_temp <= s_axis_tdata;
                        r_op        <= OP_STEP;
                        r_state     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_stat.done) begin
                        case (r_op)
                            OP_STEP: begin
                                r_integ <= int_next;
                                r_op    <= OP_PROP;
                                r_state <= S_LOAD;
                            end
                            OP_PROP: begin
                                r_p     <= quo_s[15:0];
                                r_op    <= OP_INT1;
                                r_state <= S_LOAD;
                            end
                            OP_INT1: begin
                                r_i1    <= quo_s[15:0];
                                r_op    <= OP_INT2;
                                r_state <= S_LOAD;
                            end
                            OP_INT2: begin
                                r_i     <= quo_s[15:0];
                                r_op    <= OP_DERIV;
                                r_state <= S_LOAD;
                            end
                            OP_DERIV: begin
                                r_d     <= quo_s;
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b000, r_d, i_field, r_p, drive};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd99))
        else $error("drive percent out of range");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SumW'(r_integ) <= int_lim) && (SumW'(r_integ) >= -int_lim))
        else $error("integral outside its limit");

endmodule
